@@ rtl/core/qte_pkg.sv @@
`timescale 1ns / 1ps
package qte_pkg;

	localparam int Q_W    = 16;
	localparam int P_W    = 32;
	localparam int T_W    = 34;
	localparam int M_W    = 33;
	localparam int S_W    = 30;
	localparam int V_W    = 57;
	localparam int R_W    = 29;
	localparam int X_W    = 37;
	localparam int Z_W    = 34;
	localparam int A_W    = 16;
	localparam int PR_W   = 64;
	localparam int SQRT_STEPS = 29;

	localparam logic signed [T_W-1:0] ONE_Q28   = T_W'(64'sd1 << 28);
	localparam logic signed [T_W-1:0] NEG_Q28   = -ONE_Q28;
	localparam logic [16:0]           LOCK_MUL  = 17'd100000;
	localparam logic [M_W+16:0]       LOCK_REF  = (M_W+17)'(64'd99999 << 28);
	localparam logic [V_W-1:0]        TWO_P56   = V_W'(64'd1 << 56);
	localparam logic signed [Z_W-1:0] HALF_TURN = Z_W'(64'sd1 << 31);
	localparam logic [30:0]           PI_Q29    = 31'd1686629713;
	localparam logic [16:0]           ANGLE_MAX = 17'd25736;

	typedef enum logic [2:0] {
		ORD_XYZ = 3'd0,
		ORD_YXZ = 3'd1,
		ORD_XZY = 3'd2,
		ORD_YZX = 3'd3,
		ORD_ZXY = 3'd4,
		ORD_ZYX = 3'd5
	} order_t;

	typedef struct packed {
		logic signed [T_W-1:0] yz_p;
		logic signed [T_W-1:0] yz_m;
		logic signed [T_W-1:0] xz_p;
		logic signed [T_W-1:0] xz_m;
		logic signed [T_W-1:0] xy_p;
		logic signed [T_W-1:0] xy_m;
		logic signed [T_W-1:0] dx;
		logic signed [T_W-1:0] dy;
		logic signed [T_W-1:0] dz;
	} terms_t;

	typedef struct packed {
		order_t                order;
		logic                  lk;
		logic signed [S_W-1:0] sc;
		logic signed [T_W-1:0] n1;
		logic signed [T_W-1:0] d1;
		logic signed [T_W-1:0] n2;
		logic signed [T_W-1:0] d2;
	} side_t;

	typedef struct packed {
		order_t     order;
		logic       lk;
		logic [2:0] zero;
	} tag_t;

	function automatic logic [31:0] atan_ba(input int unsigned i);
		logic [31:0] r;
		case (i)
			0:  r = 32'h20000000;
			1:  r = 32'h12E4051E;
			2:  r = 32'h09FB385B;
			3:  r = 32'h051111D4;
			4:  r = 32'h028B0D43;
			5:  r = 32'h0145D7E1;
			6:  r = 32'h00A2F61E;
			7:  r = 32'h00517C55;
			8:  r = 32'h0028BE53;
			9:  r = 32'h00145F2F;
			10: r = 32'h000A2F98;
			11: r = 32'h000517CC;
			12: r = 32'h00028BE6;
			13: r = 32'h000145F3;
			14: r = 32'h0000A2FA;
			15: r = 32'h0000517D;
			16: r = 32'h000028BE;
			17: r = 32'h0000145F;
			18: r = 32'h00000A30;
			19: r = 32'h00000518;
			20: r = 32'h0000028C;
			21: r = 32'h00000146;
			22: r = 32'h000000A3;
			23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/quaternion_to_euler_converter.sv @@
`timescale 1ns / 1ps
// Converts one unit quaternion (x, y, z, w in Q2.14, x in the lowest bits of s_tdata) per item
// into three Euler angles in Q3.13 radians for the rotation order held in the configuration
// register, with the gimbal-lock flag on m_tuser. A new item is taken in every cycle while the
// output side takes results; the pipeline holds five setup stages, a 29-cell square-root chain,
// one pre-rotation stage, one CORDIC cell per stage and two conversion stages.
// A stalled output stalls the whole pipeline. Write the register only while the block is idle.
module quaternion_to_euler_converter import qte_pkg::*; #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // quat_x, quat_y, quat_z, quat_w
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // angle_x, angle_y, angle_z
	output logic        m_tuser    // gimbal_locked
);

	localparam int NV   = 37 + CORDIC_STAGES;
	localparam int V_PRE = 34;
	localparam int V_CA  = 35 + CORDIC_STAGES;

	logic          en;
	logic [NV-1:0] pipe_v_q;
	logic [2:0]    order_q;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = pipe_v_q[NV-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_v_q <= '0;
			order_q  <= '0;
		end else begin
			if (cfg_wr_en) order_q <= cfg_wr_data;
			if (en) pipe_v_q <= {pipe_v_q[NV-2:0], s_tvalid};
		end
	end

	// Stage 1: products.
	logic signed [Q_W-1:0] qx, qy, qz, qw;
	logic signed [P_W-1:0] xx_s1, yy_s1, zz_s1, ww_s1, xy_s1, xz_s1, xw_s1, yz_s1, yw_s1, zw_s1;
	order_t                ord_s1;

	assign qx = s_tdata[15:0];
	assign qy = s_tdata[31:16];
	assign qz = s_tdata[47:32];
	assign qw = s_tdata[63:48];

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1 <= qx * qx;
			yy_s1 <= qy * qy;
			zz_s1 <= qz * qz;
			ww_s1 <= qw * qw;
			xy_s1 <= qx * qy;
			xz_s1 <= qx * qz;
			xw_s1 <= qx * qw;
			yz_s1 <= qy * qz;
			yw_s1 <= qy * qw;
			zw_s1 <= qz * qw;
			ord_s1 <= (order_q <= 3'd5) ? order_t'(order_q) : ORD_XYZ;
		end
	end

	// Stage 2: doubled sums.
	terms_t tm_s2, tm_s3, tm_s4;
	order_t ord_s2, ord_s3, ord_s4;

	function automatic logic signed [T_W-1:0] dsum(input logic signed [P_W-1:0] a,
		input logic signed [P_W-1:0] b, input logic sub);
		logic signed [T_W-1:0] ea, eb;
		ea = T_W'(a);
		eb = T_W'(b);
		return sub ? ((ea - eb) <<< 1) : ((ea + eb) <<< 1);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			tm_s2.yz_p <= dsum(yz_s1, xw_s1, 1'b0);
			tm_s2.yz_m <= dsum(xw_s1, yz_s1, 1'b1);
			tm_s2.xz_p <= dsum(xz_s1, yw_s1, 1'b0);
			tm_s2.xz_m <= dsum(yw_s1, xz_s1, 1'b1);
			tm_s2.xy_p <= dsum(xy_s1, zw_s1, 1'b0);
			tm_s2.xy_m <= dsum(zw_s1, xy_s1, 1'b1);
			tm_s2.dx   <= dsum(ww_s1, xx_s1, 1'b0) - ONE_Q28;
			tm_s2.dy   <= dsum(ww_s1, yy_s1, 1'b0) - ONE_Q28;
			tm_s2.dz   <= dsum(ww_s1, zz_s1, 1'b0) - ONE_Q28;
			ord_s2     <= ord_s1;
		end
	end

	// Stage 3: sine term, magnitude and clamp.
	logic signed [T_W-1:0] s_sel;
	logic [M_W-1:0]        ms_s3;
	logic signed [S_W-1:0] sc_s3, sc_s4;

	always_comb begin
		unique case (ord_s2)
			ORD_YXZ: s_sel = tm_s2.yz_m;
			ORD_XZY: s_sel = tm_s2.xy_m;
			ORD_YZX: s_sel = tm_s2.xy_p;
			ORD_ZXY: s_sel = tm_s2.yz_p;
			ORD_ZYX: s_sel = tm_s2.xz_m;
			default: s_sel = tm_s2.xz_p;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ms_s3  <= s_sel[T_W-1] ? M_W'(-s_sel) : M_W'(s_sel);
			sc_s3  <= (s_sel > ONE_Q28) ? S_W'(ONE_Q28) :
			          (s_sel < NEG_Q28) ? S_W'(NEG_Q28) : S_W'(s_sel);
			tm_s3  <= tm_s2;
			ord_s3 <= ord_s2;
		end
	end

	// Stage 4: lock test and square.
	logic                  lk_s4;
	logic [V_W-1:0]        sq_s4;
	logic signed [2*S_W-1:0] sq_full;

	assign sq_full = sc_s3 * sc_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			lk_s4  <= ((M_W+17)'(ms_s3) * (M_W+17)'(LOCK_MUL)) >= LOCK_REF;
			sq_s4  <= sq_full[V_W-1:0];
			sc_s4  <= sc_s3;
			tm_s4  <= tm_s3;
			ord_s4 <= ord_s3;
		end
	end

	// Stage 5: radicand and lane operands.
	logic [V_W-1:0] rem_c [SQRT_STEPS+1];
	logic [R_W-1:0] root_c [SQRT_STEPS+1];
	side_t          side_c [SQRT_STEPS+1];
	side_t          side_n;

	always_comb begin
		side_n.order = ord_s4;
		side_n.lk    = lk_s4;
		side_n.sc    = sc_s4;
		side_n.n1    = '0;
		side_n.d1    = '0;
		side_n.n2    = '0;
		side_n.d2    = '0;
		unique case (ord_s4)
			ORD_YXZ: begin
				side_n.n1 = lk_s4 ? tm_s4.xz_m : tm_s4.xz_p;
				side_n.d1 = lk_s4 ? tm_s4.dx : tm_s4.dz;
				side_n.n2 = tm_s4.xy_p;
				side_n.d2 = tm_s4.dy;
			end
			ORD_XZY: begin
				side_n.n1 = lk_s4 ? tm_s4.yz_m : tm_s4.yz_p;
				side_n.d1 = lk_s4 ? tm_s4.dz : tm_s4.dy;
				side_n.n2 = tm_s4.xz_p;
				side_n.d2 = tm_s4.dx;
			end
			ORD_YZX: begin
				side_n.n1 = lk_s4 ? tm_s4.xz_p : tm_s4.xz_m;
				side_n.d1 = lk_s4 ? tm_s4.dz : tm_s4.dx;
				side_n.n2 = tm_s4.yz_m;
				side_n.d2 = tm_s4.dy;
			end
			ORD_ZXY: begin
				side_n.n1 = lk_s4 ? tm_s4.xy_p : tm_s4.xy_m;
				side_n.d1 = lk_s4 ? tm_s4.dx : tm_s4.dy;
				side_n.n2 = tm_s4.xz_m;
				side_n.d2 = tm_s4.dz;
			end
			ORD_ZYX: begin
				side_n.n1 = lk_s4 ? tm_s4.xy_m : tm_s4.xy_p;
				side_n.d1 = lk_s4 ? tm_s4.dy : tm_s4.dx;
				side_n.n2 = tm_s4.yz_p;
				side_n.d2 = tm_s4.dz;
			end
			default: begin
				side_n.n1 = lk_s4 ? tm_s4.yz_p : tm_s4.yz_m;
				side_n.d1 = lk_s4 ? tm_s4.dy : tm_s4.dz;
				side_n.n2 = tm_s4.xy_m;
				side_n.d2 = tm_s4.dx;
			end
		endcase
		// The angle that the lock branch does not compute comes from a zero vector.
		if (lk_s4) begin
			side_n.n2 = '0;
			side_n.d2 = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_c[0]  <= TWO_P56 - sq_s4;
			root_c[0] <= '0;
			side_c[0] <= side_n;
		end
	end

	// Square-root chain, one result bit per cell.
	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		qte_sqrt_cell #(.K(SQRT_STEPS - 1 - j)) u_cell (
			.clk     (clk),
			.en      (en),
			.rem_in  (rem_c[j]),
			.root_in (root_c[j]),
			.side_in (side_c[j]),
			.rem_s1  (rem_c[j+1]),
			.root_s1 (root_c[j+1]),
			.side_s1 (side_c[j+1])
		);
	end

	// Pre-rotation by half a turn for vectors in the left half plane.
	side_t                 sd;
	logic signed [X_W-1:0] ln_n [3];
	logic signed [X_W-1:0] ln_d [3];
	logic signed [X_W-1:0] cx [3][CORDIC_STAGES+1];
	logic signed [X_W-1:0] cy [3][CORDIC_STAGES+1];
	logic signed [Z_W-1:0] cz [3][CORDIC_STAGES+1];
	tag_t                  tag_q [CORDIC_STAGES+1];

	assign sd      = side_c[SQRT_STEPS];
	assign ln_n[0] = X_W'(sd.sc);
	assign ln_d[0] = $signed(X_W'(root_c[SQRT_STEPS]));
	assign ln_n[1] = X_W'(sd.n1);
	assign ln_d[1] = X_W'(sd.d1);
	assign ln_n[2] = X_W'(sd.n2);
	assign ln_d[2] = X_W'(sd.d2);

	for (genvar l = 0; l < 3; l++) begin : g_lane
		always_ff @(posedge clk) begin
			if (en) begin
				tag_q[0].zero[l] <= (ln_n[l] == '0) && (ln_d[l] == '0);
				if (ln_d[l][X_W-1]) begin
					cx[l][0] <= -ln_d[l];
					cy[l][0] <= -ln_n[l];
					cz[l][0] <= ln_n[l][X_W-1] ? -HALF_TURN : HALF_TURN;
				end else begin
					cx[l][0] <= ln_d[l];
					cy[l][0] <= ln_n[l];
					cz[l][0] <= '0;
				end
			end
		end

		for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
			qte_cordic_cell #(.IDX(i)) u_cell (
				.clk  (clk),
				.en   (en),
				.x_in (cx[l][i]),
				.y_in (cy[l][i]),
				.z_in (cz[l][i]),
				.x_s1 (cx[l][i+1]),
				.y_s1 (cy[l][i+1]),
				.z_s1 (cz[l][i+1])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_q[0].order <= sd.order;
			tag_q[0].lk    <= sd.lk;
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_tag
		always_ff @(posedge clk) begin
			if (en) tag_q[i+1] <= tag_q[i];
		end
	end

	// Binary angle to radians: magnitude times pi, then round and saturate.
	logic [PR_W-1:0] prod_ca [3];
	logic [2:0]      neg_ca;
	tag_t            tag_ca;
	logic signed [A_W-1:0] ang [3];

	for (genvar l = 0; l < 3; l++) begin : g_conv
		logic signed [Z_W-1:0] zf;
		logic [M_W-1:0]        mag;
		logic [PR_W-1:0]       rnd;
		logic [16:0]           q;

		assign zf  = tag_q[CORDIC_STAGES].zero[l] ? '0 : cz[l][CORDIC_STAGES];
		assign mag = zf[Z_W-1] ? M_W'(-zf) : M_W'(zf);

		always_ff @(posedge clk) begin
			if (en) begin
				prod_ca[l] <= PR_W'(mag) * PR_W'(PI_Q29);
				neg_ca[l]  <= zf[Z_W-1];
			end
		end

		assign rnd = (prod_ca[l] + (PR_W'(1) << 46)) >> 47;
		assign q   = (rnd > PR_W'(ANGLE_MAX)) ? ANGLE_MAX : rnd[16:0];
		assign ang[l] = neg_ca[l] ? -A_W'(q) : A_W'(q);
	end

	always_ff @(posedge clk) begin
		if (en) tag_ca <= tag_q[CORDIC_STAGES];
	end

	// Output register: place asin, lock-side and zeroed lanes on their axes.
	always_ff @(posedge clk) begin
		if (en) begin
			m_tuser <= tag_ca.lk;
			unique case (tag_ca.order)
				ORD_YXZ: m_tdata <= {ang[2], ang[1], ang[0]};
				ORD_XZY: m_tdata <= {ang[0], ang[2], ang[1]};
				ORD_YZX: m_tdata <= {ang[0], ang[1], ang[2]};
				ORD_ZXY: m_tdata <= {ang[1], ang[2], ang[0]};
				ORD_ZYX: m_tdata <= {ang[1], ang[0], ang[2]};
				default: m_tdata <= {ang[2], ang[0], ang[1]};
			endcase
		end
	end

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd25736 &&
		$signed(m_tdata[15:0]) >= -16'sd25736 &&
		$signed(m_tdata[31:16]) <= 16'sd25736 &&
		$signed(m_tdata[31:16]) >= -16'sd25736 &&
		$signed(m_tdata[47:32]) <= 16'sd25736 &&
		$signed(m_tdata[47:32]) >= -16'sd25736))
		else $error("angle out of range");

	a_zero_vector: assert property (@(posedge clk) disable iff (!arst_n)
		(en && pipe_v_q[V_CA-1] && tag_q[CORDIC_STAGES].zero[2]) |=> (prod_ca[2] == '0))
		else $error("zero vector gave nonzero angle");

	a_lock_zero_lane: assert property (@(posedge clk) disable iff (!arst_n)
		(en && pipe_v_q[V_PRE-1] && sd.lk) |=> tag_q[0].zero[2])
		else $error("locked item without zeroed lane");

endmodule

@@ rtl/core/qte_sqrt_cell.sv @@
`timescale 1ns / 1ps
module qte_sqrt_cell import qte_pkg::*; #(
	parameter int K = 28
) (
	input  logic           clk,
	input  logic           en,
	input  logic [V_W-1:0] rem_in,
	input  logic [R_W-1:0] root_in,
	input  side_t          side_in,
	output logic [V_W-1:0] rem_s1,
	output logic [R_W-1:0] root_s1,
	output side_t          side_s1
);

	logic [V_W+1:0] trial;
	logic           fits;

	assign trial = ((V_W+2)'(root_in) << (K + 1)) + ((V_W+2)'(1) << (2 * K));
	assign fits  = {2'b00, rem_in} >= trial;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1  <= fits ? V_W'({2'b00, rem_in} - trial) : rem_in;
			root_s1 <= fits ? (root_in | (R_W'(1) << K)) : root_in;
			side_s1 <= side_in;
		end
	end

endmodule

@@ rtl/core/qte_cordic_cell.sv @@
`timescale 1ns / 1ps
module qte_cordic_cell import qte_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [X_W-1:0] x_in,
	input  logic signed [X_W-1:0] y_in,
	input  logic signed [Z_W-1:0] z_in,
	output logic signed [X_W-1:0] x_s1,
	output logic signed [X_W-1:0] y_s1,
	output logic signed [Z_W-1:0] z_s1
);

	logic signed [X_W-1:0] xs, ys;
	logic signed [Z_W-1:0] step;

	assign xs   = x_in >>> IDX;
	assign ys   = y_in >>> IDX;
	assign step = $signed({2'b00, atan_ba(IDX)});

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_in[X_W-1]) begin
				x_s1 <= x_in + ys;
				y_s1 <= y_in - xs;
				z_s1 <= z_in + step;
			end else begin
				x_s1 <= x_in - ys;
				y_s1 <= y_in + xs;
				z_s1 <= z_in - step;
			end
		end
	end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
	import qte_pkg::*;

	localparam int STAGES = 16;
	localparam int LATENCY = 37 + STAGES;
	localparam int N_RANDOM = 1472;

	typedef struct {
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic               lk;
	} angles_t;

	typedef struct {
		logic [15:0] qx;
		logic [15:0] qy;
		logic [15:0] qz;
		logic [15:0] qw;
		bit          known;
		angles_t     res;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_wr_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tuser;

	logic [2:0] cur_order = 3'd0;
	angles_t    angles_pending[$];
	int         mismatches = 0;
	int         results_seen = 0;
	int         locked_seen = 0;
	bit         out_done = 1'b0;
	row_t       directed[$];

	quaternion_to_euler_converter #(.CORDIC_STAGES(STAGES)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #6 clk = ~clk;

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic logic signed [15:0] binary_to_rad(longint a);
		bit neg;
		logic [63:0] mag, q;
		neg = a < 0;
		mag = neg ? -a : a;
		q = (mag * 64'd1686629713 + (64'd1 << 46)) >> 47;
		if (q > 25736) q = 25736;
		return neg ? -q[15:0] : q[15:0];
	endfunction

	function automatic logic signed [15:0] atan2_fix(longint n, longint d);
		longint x, y, z, xs, ys;
		x = d; y = n; z = 0;
		if (x == 0 && y == 0) return 16'sd0;
		if (x < 0) begin
			z = (y >= 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STAGES && i < 24; i++) begin
			xs = shr_floor(x, i);
			ys = shr_floor(y, i);
			if (y >= 0) begin
				x += ys; y -= xs; z += longint'(atan_ba(i));
			end else begin
				x -= ys; y += xs; z -= longint'(atan_ba(i));
			end
		end
		return binary_to_rad(z);
	endfunction

	function automatic logic [63:0] sqrt_floor(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic signed [15:0] asin_fix(longint s);
		longint one;
		logic [63:0] sq;
		one = 64'sd1 <<< 28;
		if (s > one) s = one;
		if (s < -one) s = -one;
		sq = s * s;
		return atan2_fix(s, longint'(sqrt_floor((64'd1 << 56) - sq)));
	endfunction

	function automatic angles_t euler_of(logic [2:0] ord, logic [15:0] qx, logic [15:0] qy,
			logic [15:0] qz, logic [15:0] qw);
		longint x, y, z, w, yzp, yzm, xzp, xzm, xyp, xym, dx, dy, dz, s, ms, one;
		order_t o;
		angles_t r;
		x = longint'($signed(qx)); y = longint'($signed(qy));
		z = longint'($signed(qz)); w = longint'($signed(qw));
		one = 64'sd1 <<< 28;
		yzp = 2*y*z + 2*x*w; yzm = 2*x*w - 2*y*z;
		xzp = 2*x*z + 2*y*w; xzm = 2*y*w - 2*x*z;
		xyp = 2*x*y + 2*z*w; xym = 2*z*w - 2*x*y;
		dx = 2*w*w + 2*x*x - one;
		dy = 2*w*w + 2*y*y - one;
		dz = 2*w*w + 2*z*z - one;
		o = (ord <= 3'd5) ? order_t'(ord) : ORD_XYZ;
		case (o)
			ORD_YXZ: s = yzm;
			ORD_XZY: s = xym;
			ORD_YZX: s = xyp;
			ORD_ZXY: s = yzp;
			ORD_ZYX: s = xzm;
			default: s = xzp;
		endcase
		ms = (s < 0) ? -s : s;
		r.lk = ms * 100000 >= 64'sd99999 * one;
		r.ax = 0; r.ay = 0; r.az = 0;
		case (o)
			ORD_YXZ: begin
				r.ax = asin_fix(s);
				r.ay = r.lk ? atan2_fix(xzm, dx) : atan2_fix(xzp, dz);
				r.az = r.lk ? 16'sd0 : atan2_fix(xyp, dy);
			end
			ORD_XZY: begin
				r.az = asin_fix(s);
				r.ax = r.lk ? atan2_fix(yzm, dz) : atan2_fix(yzp, dy);
				r.ay = r.lk ? 16'sd0 : atan2_fix(xzp, dx);
			end
			ORD_YZX: begin
				r.az = asin_fix(s);
				r.ax = r.lk ? 16'sd0 : atan2_fix(yzm, dy);
				r.ay = r.lk ? atan2_fix(xzp, dz) : atan2_fix(xzm, dx);
			end
			ORD_ZXY: begin
				r.ax = asin_fix(s);
				r.ay = r.lk ? 16'sd0 : atan2_fix(xzm, dz);
				r.az = r.lk ? atan2_fix(xyp, dx) : atan2_fix(xym, dy);
			end
			ORD_ZYX: begin
				r.ay = asin_fix(s);
				r.ax = r.lk ? 16'sd0 : atan2_fix(yzp, dz);
				r.az = r.lk ? atan2_fix(xym, dy) : atan2_fix(xyp, dx);
			end
			default: begin
				r.ay = asin_fix(s);
				r.ax = r.lk ? atan2_fix(yzp, dy) : atan2_fix(yzm, dz);
				r.az = r.lk ? 16'sd0 : atan2_fix(xym, dx);
			end
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic write_order(logic [2:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cur_order = value;
	endtask

	task automatic send_quat(logic [15:0] qx, logic [15:0] qy, logic [15:0] qz,
			logic [15:0] qw, int gap, bit known, angles_t res);
		angles_t e;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		e = known ? res : euler_of(cur_order, qx, qy, qz, qw);
		s_tvalid <= 1'b1;
		s_tdata <= {qw, qz, qy, qx};
		do @(posedge clk); while (!s_tready);
		angles_pending.push_back(e);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (angles_pending.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	function automatic logic [15:0] rand_comp();
		int p;
		p = $urandom_range(0, 9);
		if (p == 0) return 16'($urandom);
		if (p == 1) return 16'($signed($urandom_range(0, 32768)) - 16384);
		return 16'($signed($urandom_range(0, 32768)) - 16384);
	endfunction

	task automatic send_unit_quat();
		real a, b, c, d, n;
		logic [15:0] q[4];
		int p;
		p = $urandom_range(0, 9);
		a = $itor($signed($urandom_range(0, 2000)) - 1000);
		b = $itor($signed($urandom_range(0, 2000)) - 1000);
		c = $itor($signed($urandom_range(0, 2000)) - 1000);
		d = $itor($signed($urandom_range(0, 2000)) - 1000);
		if (p < 3) begin
			// Near gimbal lock: two components dominate with equal magnitude.
			a = 1000.0; b = ($urandom_range(0, 1) ? 1000.0 : -1000.0);
			c = $itor($urandom_range(0, 3)) - 1.5; d = $itor($urandom_range(0, 3)) - 1.5;
		end
		n = $sqrt(a*a + b*b + c*c + d*d);
		if (n < 1.0) n = 1.0;
		q[0] = 16'($rtoi(a / n * 16384.0));
		q[1] = 16'($rtoi(b / n * 16384.0));
		q[2] = 16'($rtoi(c / n * 16384.0));
		q[3] = 16'($rtoi(d / n * 16384.0));
		q.shuffle();
		send_quat(q[0], q[1], q[2], q[3], pick_gap(), 1'b0, '{0, 0, 0, 0});
	endtask

	always @(posedge clk) begin
		angles_t e;
		if (m_tvalid && m_tready) begin
			results_seen++;
			if (m_tuser) locked_seen++;
			if (angles_pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h lock %b", m_tdata, m_tuser);
			end else begin
				e = angles_pending.pop_front();
				if (m_tdata !== {e.az, e.ay, e.ax} || m_tuser !== e.lk) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected x %0d y %0d z %0d lock %b, got x %0d y %0d z %0d lock %b",
							e.ax, e.ay, e.az, e.lk, $signed(m_tdata[15:0]),
							$signed(m_tdata[31:16]), $signed(m_tdata[47:32]), m_tuser);
				end
			end
		end
	end

	initial begin
		int g;
		m_tready = 1'b0;
		while (!out_done) begin
			@(negedge clk);
			if ($urandom_range(0, 3) == 0) begin
				g = pick_gap();
				if (g > 0) begin
					m_tready <= 1'b0;
					repeat (g) @(negedge clk);
				end
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(20, 60))
				@(negedge clk);
		end
	end

	initial begin
		#20ms;
		$display("testbench: done, errors");
		$finish;
	end

	initial begin
		logic [2:0] orders[8] = '{3'd0, 3'd5, 3'd1, 3'd7, 3'd2, 3'd3, 3'd4, 3'd6};
		angles_t zero_res;
		zero_res = '{0, 0, 0, 0};
		// The identity gives zero angles in every order.
		directed.push_back('{16'd0, 16'd0, 16'd0, 16'sd16384, 1'b1, zero_res});
		directed.push_back('{16'd0, 16'd0, 16'd0, 16'd0, 1'b0, zero_res});
		directed.push_back('{16'sd16384, 16'd0, 16'd0, 16'd0, 1'b0, zero_res});
		directed.push_back('{16'd0, 16'sd16384, 16'd0, 16'd0, 1'b0, zero_res});
		directed.push_back('{16'd0, 16'd0, 16'sd16384, 16'd0, 1'b0, zero_res});
		directed.push_back('{16'd0, 16'd0, 16'd0, -16'sd16384, 1'b0, zero_res});
		directed.push_back('{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 1'b0, zero_res});
		directed.push_back('{-16'sd8192, 16'sd8192, -16'sd8192, 16'sd8192, 1'b0, zero_res});
		directed.push_back('{16'sd11585, 16'sd11585, 16'd0, 16'd0, 1'b0, zero_res});
		directed.push_back('{16'sd11585, 16'd0, 16'sd11585, 16'd0, 1'b0, zero_res});
		directed.push_back('{16'd0, 16'sd11585, 16'd0, 16'sd11585, 1'b0, zero_res});
		directed.push_back('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, zero_res});
		directed.push_back('{16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, zero_res});
		directed.push_back('{16'h8000, 16'sd32767, 16'h8000, 16'sd32767, 1'b0, zero_res});
		directed.push_back('{16'hFFFF, 16'h0001, 16'hFFFF, 16'h5555, 1'b0, zero_res});
		directed.push_back('{16'hAAAA, 16'h5555, 16'h0000, 16'hFFFF, 1'b0, zero_res});

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Reset order is XYZ.
		foreach (directed[i])
			send_quat(directed[i].qx, directed[i].qy, directed[i].qz, directed[i].qw,
				pick_gap(), directed[i].known, directed[i].res);
		drain();

		foreach (orders[k]) begin
			write_order(orders[k]);
			foreach (directed[i])
				send_quat(directed[i].qx, directed[i].qy, directed[i].qz, directed[i].qw,
					(i < 4) ? 0 : pick_gap(), directed[i].known, directed[i].res);
			for (int n = 0; n < N_RANDOM / 8; n++) begin
				if ($urandom_range(0, 9) < 8)
					send_unit_quat();
				else
					send_quat(rand_comp(), rand_comp(), rand_comp(), 16'($urandom),
						pick_gap(), 1'b0, zero_res);
			end
			drain();
		end

		out_done = 1'b1;
		$display("Converted %0d quaternions over all six orders and both unused codes,",
			results_seen);
		$display("%0d of them in gimbal lock, %0d mismatches.", locked_seen, mismatches);
		if (mismatches == 0 && angles_pending.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
